// File: rtl/lebenc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lebenc_pkg;

  // Widths of the stream fields and of the leftover register.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned SeptW    = 7;
  localparam int unsigned PendW    = 6;
  localparam int unsigned CountW   = 3;
  localparam int unsigned AccW     = PendW + ByteW;

  // Largest leftover count; a septet needs one bit more.
  localparam logic [CountW-1:0] MaxPend = CountW'(PendW);

  // Continuation flag position inside an encoded byte.
  localparam int unsigned ContBit  = 7;

  // One encoded word on the result side.
  typedef struct packed {
    logic [ByteW-1:0] leb_byte;
    logic             last_of_run;
  } leb_res_t;

  // Words produced by one input word, handed to the output queue.
  typedef struct packed {
    logic     push;
    logic     two;
    leb_res_t r0;
    leb_res_t r1;
  } leb_push_t;

  // Mask with the lowest n bits set, n from 0 to PendW.
  function automatic logic [PendW-1:0] low_mask(input logic [CountW-1:0] n);
    logic [PendW-1:0] m;
    for (int i = 0; i < PendW; i++) begin
      m[i] = (CountW'(i) < n);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lebenc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module lebenc_core
  import lebenc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             is_last_i,
  input  wire logic             signed_mode_i,
  output leb_push_t             push_o
);

  logic [PendW-1:0]  pend_bits_q, pend_bits_d;
  logic [CountW-1:0] pend_cnt_q, pend_cnt_d;
  logic [CountW-1:0] cnt;
  logic [AccW-1:0]   acc;
  logic [SeptW-1:0]  sept0;
  logic [SeptW-1:0]  rest;
  logic [CountW-1:0] rem;
  logic [SeptW-1:0]  keep;
  logic [SeptW-1:0]  fin;
  logic              sign_bit;

  // Join the leftover bits with the new byte and cut the septets.
  always_comb begin
    cnt      = (pend_cnt_q > MaxPend) ? MaxPend : pend_cnt_q;
    acc      = {ByteW'(0), pend_bits_q & low_mask(cnt)}
             | ({PendW'(0), data_byte_i} << cnt);
    sept0    = acc[SeptW-1:0];
    rest     = acc[AccW-1:SeptW];
    rem      = cnt + CountW'(1);
    keep     = {1'b0, low_mask(rem)};
    sign_bit = rest[cnt];
    fin      = (rest & keep) | ((signed_mode_i && sign_bit) ? ~keep : '0);

    push_o.push              = fire_i;
    push_o.r0.leb_byte       = {1'b1, sept0};
    push_o.r0.last_of_run    = 1'b0;
    push_o.two               = 1'b0;
    push_o.r1.leb_byte       = {1'b0, fin};
    push_o.r1.last_of_run    = 1'b1;
    pend_bits_d              = rest[PendW-1:0];
    pend_cnt_d               = rem;

    if (cnt == MaxPend) begin
      // Six bits pending: the byte completes two septets, nothing is left.
      push_o.two            = 1'b1;
      push_o.r1.leb_byte    = {!is_last_i, rest};
      push_o.r1.last_of_run = is_last_i;
      pend_bits_d           = '0;
      pend_cnt_d            = '0;
    end else if (is_last_i) begin
      // Flush the leftover bits as a padded final septet.
      push_o.two  = 1'b1;
      pend_bits_d = '0;
      pend_cnt_d  = '0;
    end
  end

  // Leftover register, updated on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else if (fire_i) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lebenc_outq.sv
`timescale 1ns / 1ps
`default_nettype none

module lebenc_outq
  import lebenc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire leb_push_t push_i,
  output logic           ready_o,
  output leb_res_t       head_o,
  output logic           valid_o,
  input  wire logic      pop_i
);

  leb_res_t   slot0_q, slot0_d;
  leb_res_t   slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = pop_i && (cnt_q != 2'd0);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = slot0_q;
  // A new word is taken once the queue drains this cycle.
  assign ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  // Next slot contents and fill count.
  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (push_i.push) begin
      slot0_d = push_i.r0;
      slot1_d = push_i.r1;
      cnt_d   = push_i.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  // Fill count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload slots.
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

`default_nettype wire

// File: rtl/leb128_stream_encoder_unit.sv
// LEB128 stream encoder.
// The slave channel takes the bytes of a number, least significant byte
// first; tlast marks the most significant byte and tuser selects signed
// padding for the final septet. The master channel returns encoded bytes:
// a septet in bits 6..0 and the continuation flag in bit 7, with tlast on
// the final byte of the number. A number of n bytes gives ceil(8n/7) words.
// Each accepted word yields one or two result words, registered in a
// two-slot output queue; the first appears in the cycle after acceptance.
// A new input word is taken only when the queue is empty or its last
// result word is taken in that cycle, so the rate of input words is set by
// the single result word per cycle of the master channel.
// Reset empties the output queue and clears the leftover-bit register.
// When the receiver stalls, the queue holds its words and s_axis_tready_o
// stays low until the queue is about to drain.
`timescale 1ns / 1ps
`default_nettype none

module leb128_stream_encoder_unit
  import lebenc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [ByteW-1:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic             s_axis_tlast_i,   // is_last
  input  wire logic             s_axis_tuser_i,   // [0] signed_mode
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [ByteW-1:0]      m_axis_tdata_o,   // [7:0] leb_byte
  output logic                  m_axis_tlast_o    // last_of_run
);

  leb_push_t push;
  leb_res_t  head;
  logic      fire;

  assign fire = s_axis_tvalid_i && s_axis_tready_o;

  // Septet forming and leftover bits.
  lebenc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .data_byte_i   (s_axis_tdata_i),
    .is_last_i     (s_axis_tlast_i),
    .signed_mode_i (s_axis_tuser_i),
    .push_o        (push)
  );

  // Result queue on the master side.
  lebenc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (s_axis_tready_o),
    .head_o  (head),
    .valid_o (m_axis_tvalid_o),
    .pop_i   (m_axis_tready_i)
  );

  assign m_axis_tdata_o = head.leb_byte;
  assign m_axis_tlast_o = head.last_of_run;

endmodule

`default_nettype wire
